// ===== hdl/hrt_pkg.sv =====
// ----------------------------------------------------------------------------
// hrt_pkg
// Types and constants shared by the HTTP request header tokenizer.
// ----------------------------------------------------------------------------
package hrt_pkg;

  localparam int TOKEN_BYTES = 128;
  localparam int VALUE_LIMIT = 126;
  localparam int CNT_W       = $clog2(TOKEN_BYTES);
  localparam int LEN_W       = 7;

  localparam logic [CNT_W-1:0] TOKEN_CAP = CNT_W'(TOKEN_BYTES - 1);
  localparam logic [CNT_W-1:0] VALUE_CAP = CNT_W'(VALUE_LIMIT);

  localparam logic OP_DATA    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam logic [2:0] KIND_METHOD  = 3'd0;
  localparam logic [2:0] KIND_URI     = 3'd1;
  localparam logic [2:0] KIND_VERSION = 3'd2;
  localparam logic [2:0] KIND_NAME    = 3'd3;
  localparam logic [2:0] KIND_VALUE   = 3'd4;

  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef enum logic [2:0] {
    PHASE_METHOD  = 3'd0,
    PHASE_URI     = 3'd1,
    PHASE_VERSION = 3'd2,
    PHASE_NAME    = 3'd3,
    PHASE_VALUE   = 3'd4,
    PHASE_DONE    = 3'd5
  } phase_t;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [2:0]       token_kind;
    logic             byte_valid;
    logic [7:0]       token_byte;
    logic             token_end;
    logic [LEN_W-1:0] token_length;
    logic             request_done;
  } token_t;

  typedef struct packed {
    logic             present;
    phase_t           phase_next;
    logic [CNT_W-1:0] count_next;
  } step_ctl_t;

endpackage

// ===== hdl/http_request_header_tokenizer.sv =====
// ----------------------------------------------------------------------------
// http_request_header_tokenizer
// Splits an HTTP request byte stream into method, URI, version, header
// names and values, streaming token bytes and token ends.
// ----------------------------------------------------------------------------
// Path: an accepted word waits in the input stage register; any result word
// goes to the output register as that stage advances. Throughput: one word
// per cycle unless token_ready stalls; the combinational parse step sets it.
// Reset: rst (synchronous) empties both register stages and returns the
// parser to the method phase with a zero token count.
module http_request_header_tokenizer
  import hrt_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   item_valid,
  output logic   item_ready,
  input  item_t  item,
  output logic   token_valid,
  input  logic   token_ready,
  output token_t token
);

  logic             s1_valid;
  item_t            s1_item;
  logic             s1_adv;
  phase_t           phase;
  logic [CNT_W-1:0] count;
  token_t           res;
  step_ctl_t        ctl;

  hrt_step u_step (
    .item  (s1_item),
    .phase (phase),
    .count (count),
    .res   (res),
    .ctl   (ctl)
  );

  assign s1_adv     = s1_valid && (!token_valid || token_ready);
  assign item_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      token_valid <= 1'b0;
      phase       <= PHASE_METHOD;
      count       <= '0;
    end else begin
      if (item_ready) begin
        s1_valid <= item_valid;
      end
      if (s1_adv) begin
        phase       <= ctl.phase_next;
        count       <= ctl.count_next;
        token_valid <= ctl.present;
      end else if (token_ready) begin
        token_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s1_item <= item;
    end
    if (s1_adv && ctl.present) begin
      token <= res;
    end
  end

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !token_valid |-> item_ready)
    else $error("input stalled with empty output register");

  a_value_capped: assert property (@(posedge clk) disable iff (rst)
    phase == PHASE_VALUE |-> count <= VALUE_CAP)
    else $error("value length beyond limit");

  a_done_enters_phase: assert property (@(posedge clk) disable iff (rst)
    s1_adv && ctl.present && res.request_done |=> phase == PHASE_DONE)
    else $error("request end did not enter done phase");

  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    s1_adv && phase == PHASE_DONE && s1_item.op == OP_DATA |-> !ctl.present)
    else $error("result produced after request end");

  a_byte_exclusive: assert property (@(posedge clk) disable iff (rst)
    token_valid && token.byte_valid |-> !token.token_end && !token.request_done)
    else $error("byte word also flagged as end");

endmodule

// ===== hdl/hrt_step.sv =====
// ----------------------------------------------------------------------------
// hrt_step
// Per-byte parse step: classifies one word against the current phase and
// produces the result word plus the next phase and token count.
// ----------------------------------------------------------------------------
module hrt_step
  import hrt_pkg::*;
(
  input  item_t            item,
  input  phase_t           phase,
  input  logic [CNT_W-1:0] count,
  output token_t           res,
  output step_ctl_t        ctl
);

  logic [2:0]       kind;
  logic             term;
  logic             skip;
  logic             finish;
  phase_t           term_phase;
  logic [CNT_W-1:0] cap;
  logic [7:0]       b;

  assign b = item.data_byte;

  always_comb begin
    kind       = KIND_METHOD;
    term       = 1'b0;
    skip       = 1'b0;
    finish     = 1'b0;
    term_phase = phase;
    cap        = TOKEN_CAP;
    unique case (phase)
      PHASE_METHOD: begin
        term       = (b == CH_SP);
        term_phase = PHASE_URI;
      end
      PHASE_URI: begin
        kind       = KIND_URI;
        term       = (b == CH_SP);
        term_phase = PHASE_VERSION;
      end
      PHASE_VERSION: begin
        kind       = KIND_VERSION;
        term       = (b == CH_CR);
        term_phase = PHASE_NAME;
      end
      PHASE_NAME: begin
        kind       = KIND_NAME;
        skip       = (b == CH_LF);
        finish     = (b == CH_CR);
        term       = (b == CH_COLON);
        term_phase = PHASE_VALUE;
      end
      PHASE_VALUE: begin
        kind       = KIND_VALUE;
        skip       = (b == CH_SP) && (count == '0);
        term       = (b == CH_CR);
        term_phase = PHASE_NAME;
        cap        = VALUE_CAP;
      end
      default: begin
        skip = 1'b1;
      end
    endcase
  end

  always_comb begin
    res            = '0;
    res.token_kind = kind;
    ctl.present    = 1'b0;
    ctl.phase_next = phase;
    ctl.count_next = count;
    if (item.op == OP_RESTART) begin
      ctl.phase_next = PHASE_METHOD;
      ctl.count_next = '0;
    end else if (skip) begin
      ctl.present = 1'b0;
    end else if (finish) begin
      ctl.present      = 1'b1;
      ctl.phase_next   = PHASE_DONE;
      ctl.count_next   = '0;
      res.request_done = 1'b1;
    end else if (term) begin
      ctl.present      = 1'b1;
      ctl.phase_next   = term_phase;
      ctl.count_next   = '0;
      res.token_end    = 1'b1;
      res.token_length = LEN_W'(count);
    end else if (count < cap) begin
      ctl.present    = 1'b1;
      ctl.count_next = count + 1'b1;
      res.byte_valid = 1'b1;
      res.token_byte = b;
    end
  end

endmodule

// ===== bench/http_request_header_tokenizer_tb.sv =====
// ----------------------------------------------------------------------------
// http_request_header_tokenizer_tb
// Self-checking bench for the request header tokenizer. Streams directed and
// randomly built HTTP requests through the valid/ready input, predicts every
// token word in a scoreboard and compares each output word field by field,
// under several sender idle and receiver stall mixes.
// ----------------------------------------------------------------------------
module http_request_header_tokenizer_tb;
  import hrt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES = 2;
  localparam int HOLD_CYCLES  = 60;
  localparam int IDLE_LIMIT   = 4000;
  localparam int RANDOM_ITEMS = 1900;

  class token_scoreboard;
    phase_t           phase;
    logic [CNT_W-1:0] count;
    token_t           expected_q[$];
    int               errors;

    function new();
      phase  = PHASE_METHOD;
      count  = '0;
      errors = 0;
    endfunction

    function void push(logic [2:0] kind, logic vld, logic [7:0] b, logic fin,
                       logic [LEN_W-1:0] len, logic done);
      token_t t;
      t.token_kind   = kind;
      t.byte_valid   = vld;
      t.token_byte   = b;
      t.token_end    = fin;
      t.token_length = len;
      t.request_done = done;
      expected_q.push_back(t);
    endfunction

    function void append(logic [2:0] kind, logic [7:0] b, logic [CNT_W-1:0] cap);
      if (count >= cap) return;
      count++;
      push(kind, 1'b1, b, 1'b0, '0, 1'b0);
    endfunction

    function void close_token(logic [2:0] kind, phase_t nxt);
      push(kind, 1'b0, 8'h00, 1'b1, LEN_W'(count), 1'b0);
      phase = nxt;
      count = '0;
    endfunction

    function void note_word(item_t w);
      logic [7:0] c;
      c = w.data_byte;
      if (w.op == OP_RESTART) begin
        phase = PHASE_METHOD;
        count = '0;
        return;
      end
      case (phase)
        PHASE_METHOD: begin
          if (c == CH_SP) close_token(KIND_METHOD, PHASE_URI);
          else append(KIND_METHOD, c, TOKEN_CAP);
        end
        PHASE_URI: begin
          if (c == CH_SP) close_token(KIND_URI, PHASE_VERSION);
          else append(KIND_URI, c, TOKEN_CAP);
        end
        PHASE_VERSION: begin
          if (c == CH_CR) close_token(KIND_VERSION, PHASE_NAME);
          else append(KIND_VERSION, c, TOKEN_CAP);
        end
        PHASE_NAME: begin
          if (c == CH_LF) return;
          if (c == CH_CR) begin
            phase = PHASE_DONE;
            count = '0;
            push(KIND_NAME, 1'b0, 8'h00, 1'b0, '0, 1'b1);
          end else if (c == CH_COLON) begin
            close_token(KIND_NAME, PHASE_VALUE);
          end else begin
            append(KIND_NAME, c, TOKEN_CAP);
          end
        end
        PHASE_VALUE: begin
          if (c == CH_SP && count == '0) return;
          if (c == CH_CR) close_token(KIND_VALUE, PHASE_NAME);
          else append(KIND_VALUE, c, VALUE_CAP);
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_token(token_t got);
      token_t e;
      if (expected_q.size() == 0) begin
        $error("token word with nothing expected: %h", got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      compare_field("token_kind", e.token_kind, got.token_kind);
      compare_field("byte_valid", e.byte_valid, got.byte_valid);
      compare_field("token_byte", e.token_byte, got.token_byte);
      compare_field("token_end", e.token_end, got.token_end);
      compare_field("token_length", e.token_length, got.token_length);
      compare_field("request_done", e.request_done, got.request_done);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   item_valid = 1'b0;
  logic   item_ready;
  item_t  item = '0;
  logic   token_valid;
  logic   token_ready = 1'b0;
  token_t token;

  token_scoreboard sb;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_req = 1'b0;
  int  sent = 0;
  int  idle_cycles = 0;

  http_request_header_tokenizer uut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .token_valid (token_valid),
    .token_ready (token_ready),
    .token       (token)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && item_valid && item_ready) sb.note_word(item);
    if (!rst && token_valid && token_ready) sb.check_token(token);
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (token_valid && token_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        token_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      token_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_word(item_t w, bit tally);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= w;
    do @(posedge clk); while (!item_ready);
    sent += tally;
  endtask

  task automatic send_data(logic [7:0] b);
    send_word(item_t'{OP_DATA, b}, 1'b1);
  endtask

  task automatic send_restart();
    send_word(item_t'{OP_RESTART, 8'($urandom_range(255))}, 1'b1);
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte(logic [7:0] stop_a, logic [7:0] stop_b);
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if ($urandom_range(99) < 4) return b;
    if (b == stop_a || b == stop_b) b = 8'h61;
    return b;
  endfunction

  // mostly short tokens, now and then one near or past the length cap
  task automatic send_text(logic [7:0] stop_a, logic [7:0] stop_b);
    int n;
    n = ($urandom_range(99) < 4) ? $urandom_range(120, 135) : $urandom_range(0, 8);
    repeat (n) send_data(pick_byte(stop_a, stop_b));
  endtask

  task automatic send_request();
    int hdrs;
    if ($urandom_range(99) < 92) send_restart();
    send_text(CH_SP, CH_SP);
    send_data(CH_SP);
    send_text(CH_SP, CH_SP);
    send_data(CH_SP);
    send_text(CH_CR, CH_CR);
    send_data(CH_CR);
    hdrs = $urandom_range(0, 4);
    repeat (hdrs) begin
      if ($urandom_range(99) < 90) send_data(CH_LF);
      send_text(CH_COLON, CH_CR);
      send_data(CH_COLON);
      repeat ($urandom_range(0, 3)) send_data(CH_SP);
      send_text(CH_CR, CH_CR);
      send_data(CH_CR);
      if ($urandom_range(99) < 3) send_restart();
    end
    send_data(CH_LF);
    if ($urandom_range(99) < 90) send_data(CH_CR);
    repeat ($urandom_range(0, 3)) send_word(item_t'{OP_DATA, 8'($urandom_range(255))}, 1'b0);
  endtask

  initial begin
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: full request with skipped bytes and bytes after the end, then empty tokens
    send_restart();
    send_data(8'h00);
    send_data(8'hFF);
    send_data(CH_SP);
    send_data("A");
    send_data(CH_SP);
    send_data("V");
    send_data(CH_CR);
    send_data(CH_LF);
    send_data("N");
    send_data(CH_COLON);
    send_data(CH_SP);
    send_data(CH_SP);
    send_data("v");
    send_data(CH_SP);
    send_data(CH_CR);
    send_data(CH_LF);
    send_data("x");
    send_data(CH_CR);
    send_data("z");
    send_data(CH_CR);
    send_word(item_t'{OP_RESTART, 8'hFF}, 1'b1);
    send_data(CH_SP);
    send_data(CH_SP);
    send_data(CH_CR);
    send_data(CH_COLON);
    send_data(CH_CR);
    send_data(CH_CR);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      if (ph == 0 || ph == 2) hold_req = 1'b1;
      while (sent < 25 + (ph + 1) * (RANDOM_ITEMS / 4)) begin
        send_request();
        if ($urandom_range(99) < 5) wait_drained();
      end
      wait_drained();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
